FILE: hw/rtl/ygp_pkg.sv
// Package with the shared types, constants and color tables of the YUV 4:2:0 pattern generator.
package ygp_pkg;

    // Fixed field widths of the pixel and configuration channels.
    localparam int COL_W      = 11;
    localparam int ROW_W      = 11;
    localparam int PIX_W      = 8;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Gradient dividend is row*255, which stays below 2^19.
    localparam int GRAD_W = 19;
    // Gradient quotient carries one extra bit that flags saturation.
    localparam int GQ_W   = 9;
    // Bar index quotient carries one extra bit that flags a position past the last bar.
    localparam int BQ_W   = 4;

    // Pattern codes; every other code is a blank frame.
    localparam logic [KIND_W-1:0] KIND_GRADIENT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CHECKER  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BARS     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CROSS    = 3'd3;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // Register reset values.
    localparam logic [KIND_W-1:0]     RST_KIND   = KIND_GRADIENT;
    localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 12'd480;

    localparam logic [PIX_W-1:0] NEUTRAL   = 8'd128;
    localparam logic [PIX_W-1:0] LUMA_FULL = 8'd255;
    localparam int               MIN_WIDTH = 8;

    localparam logic [PIX_W-1:0] BAR_Y [0:7] = '{8'd255, 8'd255, 8'd180, 8'd180,
                                                 8'd100, 8'd100, 8'd50,  8'd0};
    localparam logic [PIX_W-1:0] BAR_U [0:7] = '{8'd128, 8'd0,   8'd255, 8'd0,
                                                 8'd255, 8'd0,   8'd255, 8'd128};
    localparam logic [PIX_W-1:0] BAR_V [0:7] = '{8'd128, 8'd255, 8'd0,   8'd0,
                                                 8'd255, 8'd255, 8'd0,   8'd128};

    // Pixel state that travels down the divider pipeline.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              chroma_ok;
        logic [PIX_W-1:0]  fixed_luma;
        logic [GRAD_W-1:0] grad_rem;
        logic [GQ_W-1:0]   grad_q;
        logic [COL_W-1:0]  bar_rem;
        logic [BQ_W-1:0]   bar_q;
    } t_pipe;

endpackage

FILE: hw/rtl/ygp_if.sv
// Handshake interfaces for the pixel, result and configuration channels.
interface ygp_pix_if;
    import ygp_pkg::*;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

interface ygp_res_if;
    import ygp_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] chroma_v;
    modport source (output valid, output luma, output chroma_valid, output chroma_u,
                    output chroma_v, input ready);
    modport sink   (input valid, input luma, input chroma_valid, input chroma_u,
                    input chroma_v, output ready);
endinterface

interface ygp_cfg_if;
    import ygp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/yuv420_test_pattern_generator.sv
// Top level of the YUV 4:2:0 test pattern generator: entry stage, divider chain, output stage.
//
//   channel   modport  direction  payload
//   i_pix     sink     in         column[10:0], row[10:0]
//   o_res     source   out        luma[7:0], chroma_valid, chroma_u[7:0], chroma_v[7:0]
//   i_cfg     sink     in         index[1:0], data[11:0] (0 kind, 1 width, 2 height)
//
// One pixel enters per clock while o_res is not stalled; its result is registered through
// the divider chain: nine restoring stages, one quotient bit each, between an entry register
// and the output register.
// Reset is synchronous and active low; it empties the pipeline and loads the register defaults.
// A stall on o_res holds every full stage in place; ready ripples back so that a bubble
// anywhere in the pipeline still lets a new pixel in.
module yuv420_test_pattern_generator
    import ygp_pkg::*;
#(
    parameter int MAX_DIM = 2048
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ygp_pix_if.sink  i_pix,
    ygp_res_if.source o_res,
    ygp_cfg_if.sink  i_cfg
);

    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int DIV_STAGES = GQ_W;

    logic [KIND_W-1:0] cfg_kind;
    logic [DIM_W-1:0]  cfg_grad_div;
    logic [DIM_W-4:0]  cfg_bar_div;

    // The bounded height and bar width are registered here and held constant while
    // pixels flow if the user changes configuration only when idle; no logic checks it.
    ygp_cfg #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .o_kind     (cfg_kind),
        .o_grad_div (cfg_grad_div),
        .o_bar_div  (cfg_bar_div)
    );

    // Entry stage. Everything that needs no division is settled here: the chroma flag,
    // the checkerboard and crosshatch luma, and the gradient dividend row*255.
    t_pipe r_s0;
    t_pipe n_s0;
    logic  r_s0_valid;
    logic  s_valid [DIV_STAGES+1];
    logic  s_ready [DIV_STAGES+1];
    t_pipe s_data  [DIV_STAGES+1];

    always_comb begin
        n_s0.kind      = cfg_kind;
        n_s0.chroma_ok = !(i_pix.column[0] || i_pix.row[0]);
        case (cfg_kind)
            // The low bit of the sum of cell indices is the XOR of their low bits.
            KIND_CHECKER: n_s0.fixed_luma = (i_pix.column[5] ^ i_pix.row[5]) ? '0 : LUMA_FULL;
            KIND_CROSS:   n_s0.fixed_luma = ((i_pix.column[4:0] == '0) ||
                                             (i_pix.row[4:0] == '0)) ? LUMA_FULL : '0;
            default:      n_s0.fixed_luma = '0;
        endcase
        n_s0.grad_rem = GRAD_W'({i_pix.row, 8'h00}) - GRAD_W'(i_pix.row);
        n_s0.grad_q   = '0;
        n_s0.bar_rem  = i_pix.column;
        n_s0.bar_q    = '0;
    end

    assign i_pix.ready = !r_s0_valid || s_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s0_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_s0 <= n_s0;
        end
    end

    assign s_valid[0] = r_s0_valid;
    assign s_data[0]  = r_s0;

    // Divider chain, most significant quotient bit first. The top gradient bit is set
    // whenever row*255 >= 256*height, which means the gradient saturates; the top bar
    // bit is set when the column lies past the eighth bar.
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        ygp_div_stage #(
            .DIM_W (DIM_W),
            .K     (DIV_STAGES - 1 - j)
        ) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (s_valid[j]),
            .o_ready    (s_ready[j]),
            .i_data     (s_data[j]),
            .o_valid    (s_valid[j+1]),
            .i_ready    (s_ready[j+1]),
            .o_data     (s_data[j+1]),
            .i_grad_div (cfg_grad_div),
            .i_bar_div  (cfg_bar_div)
        );
    end

    // Output stage: pick the pattern's samples and register them for the result channel.
    t_pipe             last;
    logic [PIX_W-1:0]  n_luma;
    logic [PIX_W-1:0]  n_u;
    logic [PIX_W-1:0]  n_v;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_luma;
    logic [PIX_W-1:0]  r_u;
    logic [PIX_W-1:0]  r_v;
    logic              r_chroma_ok;

    assign last = s_data[DIV_STAGES];

    always_comb begin
        n_luma = '0;
        n_u    = NEUTRAL;
        n_v    = NEUTRAL;
        case (last.kind)
            KIND_GRADIENT: n_luma = last.grad_q[GQ_W-1] ? LUMA_FULL : last.grad_q[PIX_W-1:0];
            KIND_CHECKER, KIND_CROSS: n_luma = last.fixed_luma;
            KIND_BARS: begin
                if (!last.bar_q[BQ_W-1]) begin
                    n_luma = BAR_Y[last.bar_q[2:0]];
                    n_u    = BAR_U[last.bar_q[2:0]];
                    n_v    = BAR_V[last.bar_q[2:0]];
                end
            end
            default: n_luma = '0;
        endcase
    end

    assign s_ready[DIV_STAGES] = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_ready[DIV_STAGES]) begin
            r_out_valid <= s_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready[DIV_STAGES] && s_valid[DIV_STAGES]) begin
            r_luma      <= n_luma;
            r_u         <= n_u;
            r_v         <= n_v;
            r_chroma_ok <= last.chroma_ok;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.luma         = r_luma;
    assign o_res.chroma_valid = r_chroma_ok;
    assign o_res.chroma_u     = r_u;
    assign o_res.chroma_v     = r_v;

`ifndef SYNTHESIS
    // A taken pixel always lands in the entry stage.
    a_entry_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_s0_valid)
        else $error("accepted pixel did not reach the entry stage");

    // The input can only be held off when the result side is backed up.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.ready |-> i_pix.ready)
        else $error("input stalled while the output was ready");

    // The gradient divisor is bounded to at least one row.
    a_height_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_grad_div != '0)
        else $error("gradient divisor is zero");
`endif

endmodule

FILE: hw/rtl/ygp_cfg.sv
// Configuration registers with registered, bounded frame dimensions.
module ygp_cfg
    import ygp_pkg::*;
#(
    parameter int MAX_DIM = 2048,
    parameter int DIM_W   = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ygp_cfg_if.sink           i_cfg,
    output logic [KIND_W-1:0] o_kind,
    output logic [DIM_W-1:0]  o_grad_div,
    output logic [DIM_W-4:0]  o_bar_div
);

    localparam int EW = (DIM_W + 1 > CFG_DATA_W + 1) ? DIM_W + 1 : CFG_DATA_W + 1;
    localparam int RST_W_B = (640 > MAX_DIM) ? MAX_DIM : 640;
    localparam int RST_H_B = (480 > MAX_DIM) ? MAX_DIM : 480;
    localparam logic [DIM_W-1:0] RST_WB = DIM_W'(RST_W_B);
    localparam logic [DIM_W-1:0] RST_HB = DIM_W'(RST_H_B);

    logic [KIND_W-1:0]     r_kind;
    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;
    logic [DIM_W-1:0]      r_grad_div;
    logic [DIM_W-4:0]      r_bar_div;
    logic [EW-1:0]         w_ext;
    logic [EW-1:0]         h_ext;
    logic [EW-1:0]         w_bound;
    logic [EW-1:0]         h_bound;
    logic [DIM_W-1:0]      n_grad_div;
    logic [DIM_W-1:0]      w_trim;
    logic [DIM_W-4:0]      n_bar_div;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= RST_KIND;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_KIND:   r_kind   <= i_cfg.data[KIND_W-1:0];
                REG_WIDTH:  r_width  <= i_cfg.data;
                REG_HEIGHT: r_height <= i_cfg.data;
                default:    ;
            endcase
        end
    end

    // Clamp width into [8, MAX_DIM] and height into [1, MAX_DIM].
    always_comb begin
        w_ext = EW'(r_width);
        h_ext = EW'(r_height);
        if (w_ext > EW'(MAX_DIM)) begin
            w_bound = EW'(MAX_DIM);
        end else if (w_ext < EW'(MIN_WIDTH)) begin
            w_bound = EW'(MIN_WIDTH);
        end else begin
            w_bound = w_ext;
        end
        if (h_ext > EW'(MAX_DIM)) begin
            h_bound = EW'(MAX_DIM);
        end else if (h_ext == '0) begin
            h_bound = EW'(1);
        end else begin
            h_bound = h_ext;
        end
        n_grad_div = h_bound[DIM_W-1:0];
        w_trim     = w_bound[DIM_W-1:0];
        n_bar_div  = w_trim[DIM_W-1:3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grad_div <= RST_HB;
            r_bar_div  <= RST_WB[DIM_W-1:3];
        end else begin
            r_grad_div <= n_grad_div;
            r_bar_div  <= n_bar_div;
        end
    end

    assign o_kind     = r_kind;
    assign o_grad_div = r_grad_div;
    assign o_bar_div  = r_bar_div;

endmodule

FILE: hw/rtl/ygp_div_stage.sv
// One restoring-division stage that resolves quotient bit K of the gradient and, for K below BQ_W, of the bar index.
module ygp_div_stage
    import ygp_pkg::*;
#(
    parameter int DIM_W = 12,
    parameter int K     = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_pipe            i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_pipe            o_data,
    input  logic [DIM_W-1:0] i_grad_div,
    input  logic [DIM_W-4:0] i_bar_div
);

    localparam int GW = (DIM_W + GQ_W > GRAD_W) ? DIM_W + GQ_W : GRAD_W;
    localparam int XW = (DIM_W + GQ_W > COL_W) ? DIM_W + GQ_W : COL_W;
    localparam logic [GQ_W-1:0] GRAD_BIT = GQ_W'(1) << K;
    localparam logic [BQ_W-1:0] BAR_BIT  = (K < BQ_W) ? (BQ_W'(1) << K) : '0;

    logic [GW-1:0] g_rem;
    logic [GW-1:0] g_sub;
    logic [XW-1:0] x_rem;
    logic [XW-1:0] x_sub;
    t_pipe         n_data;
    t_pipe         r_data;
    logic          r_valid;

    always_comb begin
        g_rem  = GW'(i_data.grad_rem);
        g_sub  = GW'(i_grad_div) << K;
        x_rem  = XW'(i_data.bar_rem);
        x_sub  = XW'(i_bar_div) << K;
        n_data = i_data;
        if (g_rem >= g_sub) begin
            n_data.grad_rem = GRAD_W'(g_rem - g_sub);
            n_data.grad_q   = i_data.grad_q | GRAD_BIT;
        end
        if ((K < BQ_W) && (x_rem >= x_sub)) begin
            n_data.bar_rem = COL_W'(x_rem - x_sub);
            n_data.bar_q   = i_data.bar_q | BAR_BIT;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sim/tb_yuv420_test_pattern_generator.sv
// Self-checking testbench for the YUV 4:2:0 test pattern generator with randomized handshakes.
module tb_yuv420_test_pattern_generator;
    import ygp_pkg::*;

    // Largest frame dimension that the block is built for. Register values above it are clamped.
    localparam int DIM_LIMIT = 2048;

    // Pattern geometry: 32-pixel checker cells and crosshatch pitch, eight colour bars.
    localparam int CELL_SHIFT = 5;
    localparam int BAR_COUNT  = 8;
    localparam int GRAD_SCALE = 255;

    // Blank frame codes. The package only names the four real patterns.
    localparam logic [KIND_W-1:0] KIND_BLANK_FIRST = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BLANK_LAST  = 3'd7;

    // Register index 3 is not decoded by the block, so a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Largest value of a 12-bit register write and of an 11-bit position.
    localparam int DATA_MAX = 4095;
    localparam int POS_MAX  = 2047;

    // Upper bound of the random wait that each side draws before an item.
    localparam int MAX_WAIT = 13;

    // Only this many failures are printed in detail; the rest are counted.
    localparam int MAX_REPORTS = 10;

    // Cycles to linger after the last result, a little beyond the 11-register pipeline.
    localparam int TAIL_CYCLES = 16;

    // Bound on waiting for outstanding results before a phase change or the end.
    localparam int DRAIN_LIMIT = 5000;

    // Random stimulus is grouped into phases, each with its own register setting.
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 52;

    // One result item as the block delivers it.
    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma_valid;
        logic [PIX_W-1:0] chroma_u;
        logic [PIX_W-1:0] chroma_v;
    } t_yuv_sample;

    // Mirror of the three registers, the pattern computation, and the queue of
    // samples that are due from the block in the order their pixels went in.
    class pattern_scoreboard;
        logic [KIND_W-1:0]     kind;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        t_yuv_sample           pending_samples[$];
        int                    failures;

        function new();
            kind       = RST_KIND;
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            failures   = 0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("%s", msg);
            end
        endfunction

        function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_KIND:   kind = data[KIND_W-1:0];
                REG_WIDTH:  width_reg = data;
                REG_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function int unsigned active_width();
            int unsigned w;
            w = 32'(width_reg);
            if (w < MIN_WIDTH) return MIN_WIDTH;
            if (w > DIM_LIMIT) return DIM_LIMIT;
            return w;
        endfunction

        function int unsigned active_height();
            int unsigned h;
            h = 32'(height_reg);
            if (h < 1) return 1;
            if (h > DIM_LIMIT) return DIM_LIMIT;
            return h;
        endfunction

        function t_yuv_sample pattern_sample(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
            t_yuv_sample s;
            int unsigned grad;
            int unsigned bar;
            s.luma         = '0;
            s.chroma_u     = NEUTRAL;
            s.chroma_v     = NEUTRAL;
            s.chroma_valid = (col[0] == 1'b0) && (row[0] == 1'b0);
            case (kind)
                KIND_GRADIENT: begin
                    grad = 32'(row);
                    grad = (grad * GRAD_SCALE) / active_height();
                    s.luma = (grad > GRAD_SCALE) ? LUMA_FULL : grad[PIX_W-1:0];
                end
                KIND_CHECKER: begin
                    // The parity of the summed cell indices is the xor of their low bits.
                    s.luma = (col[CELL_SHIFT] ^ row[CELL_SHIFT]) ? '0 : LUMA_FULL;
                end
                KIND_BARS: begin
                    bar = 32'(col) / (active_width() / BAR_COUNT);
                    if (bar < BAR_COUNT) begin
                        s.luma     = BAR_Y[bar[2:0]];
                        s.chroma_u = BAR_U[bar[2:0]];
                        s.chroma_v = BAR_V[bar[2:0]];
                    end
                end
                KIND_CROSS: begin
                    s.luma = (col[CELL_SHIFT-1:0] == '0 || row[CELL_SHIFT-1:0] == '0) ?
                             LUMA_FULL : '0;
                end
                default: ;
            endcase
            return s;
        endfunction

        function void note_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
            pending_samples.push_back(pattern_sample(col, row));
        endfunction

        function void check_result(t_yuv_sample got);
            t_yuv_sample want;
            if (pending_samples.size() == 0) begin
                note_failure($sformatf("unexpected result: luma %0d cv %0b u %0d v %0d",
                                       got.luma, got.chroma_valid, got.chroma_u,
                                       got.chroma_v));
                return;
            end
            want = pending_samples.pop_front();
            if (got.luma !== want.luma)
                note_failure($sformatf("luma mismatch: expected %0d, got %0d",
                                       want.luma, got.luma));
            if (got.chroma_valid !== want.chroma_valid)
                note_failure($sformatf("chroma_valid mismatch: expected %0b, got %0b",
                                       want.chroma_valid, got.chroma_valid));
            if (got.chroma_u !== want.chroma_u)
                note_failure($sformatf("chroma_u mismatch: expected %0d, got %0d",
                                       want.chroma_u, got.chroma_u));
            if (got.chroma_v !== want.chroma_v)
                note_failure($sformatf("chroma_v mismatch: expected %0d, got %0d",
                                       want.chroma_v, got.chroma_v));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ygp_pix_if pix ();
    ygp_res_if res ();
    ygp_cfg_if cfg ();

    pattern_scoreboard sb;

    // Each side keeps its own calm flag. While calm it never waits, which gives
    // back-to-back stretches between the stretches with random waits.
    bit send_calm;
    bit take_calm;

    yuv420_test_pattern_generator #(
        .MAX_DIM(DIM_LIMIT)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix),
        .o_res  (res),
        .i_cfg  (cfg)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs. The slowest legal run is far shorter.
    initial begin
        #3000000;
        $display("tb_yuv420_test_pattern_generator failed");
        $finish;
    end

    // Draws how many cycles one side waits before its next item.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // All handshakes are observed at the rising edge, before the block's registers move.
    // A register write is noted first, then results are checked, then new pixels are
    // turned into expectations; a result can never belong to a pixel of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg.valid && cfg.ready) sb.note_write(cfg.index, cfg.data);
            if (res.valid && res.ready)
                sb.check_result(t_yuv_sample'({res.luma, res.chroma_valid,
                                               res.chroma_u, res.chroma_v}));
            if (pix.valid && pix.ready) sb.note_pixel(pix.column, pix.row);
        end
    end

    // Result side: before each result it may hold ready low for a random number of
    // cycles, then keeps ready high until a result is taken.
    initial begin
        int stall;
        res.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait(take_calm);
            repeat (stall) begin
                @(negedge i_clk);
                res.ready <= 1'b0;
            end
            @(negedge i_clk);
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!res.valid);
        end
    end

    // Offers one pixel after a random gap and returns at the edge that takes it.
    // Valid stays high afterwards so that a following pixel with no gap goes straight on.
    task automatic send_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        int gap;
        gap = draw_wait(send_calm);
        repeat (gap) begin
            @(negedge i_clk);
            pix.valid <= 1'b0;
        end
        @(negedge i_clk);
        pix.valid  <= 1'b1;
        pix.column <= col;
        pix.row    <= row;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    // Stops offering pixels and waits until every expected result has come back or DRAIN_LIMIT runs out.
    task automatic drain_pixels();
        int waited;
        waited = 0;
        @(negedge i_clk);
        pix.valid <= 1'b0;
        while (sb.pending_samples.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Registers are only written with the pipeline empty, so no pixel in flight
    // can see a setting that changed under it.
    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain_pixels();
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // Frame dimension values lean toward the clamp edges at both ends of the range.
    function automatic logic [CFG_DATA_W-1:0] dim_value();
        int extremes[10] = '{0, 1, 7, 8, 9, 16, 2047, 2048, 2049, 4095};
        case ($urandom_range(0, 5))
            0, 1:    return CFG_DATA_W'(extremes[$urandom_range(0, 9)]);
            2:       return CFG_DATA_W'($urandom_range(8, 64));
            default: return CFG_DATA_W'($urandom_range(0, DATA_MAX));
        endcase
    endfunction

    // Most pixels fall inside the active frame, where the patterns have structure.
    // The rest cover the whole position range, including bars past the eighth and
    // rows beyond the height.
    task automatic random_pixel();
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        if ($urandom_range(0, 3) != 0) begin
            col = COL_W'($urandom_range(0, sb.active_width() - 1));
            row = ROW_W'($urandom_range(0, sb.active_height() - 1));
        end else begin
            col = COL_W'($urandom_range(0, POS_MAX));
            row = ROW_W'($urandom_range(0, POS_MAX));
        end
        send_pixel(col, row);
    endtask

    // One random phase: a fresh pattern and frame size, then a burst of pixels.
    // The upper data bits of the pattern write are random; the block must ignore them.
    task automatic random_phase(int count);
        logic [CFG_DATA_W-1:0] kind_data;
        kind_data = CFG_DATA_W'($urandom_range(0, DATA_MAX));
        case ($urandom_range(0, 4))
            0:       kind_data[KIND_W-1:0] = KIND_GRADIENT;
            1:       kind_data[KIND_W-1:0] = KIND_CHECKER;
            2:       kind_data[KIND_W-1:0] = KIND_BARS;
            3:       kind_data[KIND_W-1:0] = KIND_CROSS;
            default: kind_data[KIND_W-1:0] =
                         KIND_W'($urandom_range(KIND_BLANK_FIRST, KIND_BLANK_LAST));
        endcase
        set_register(REG_KIND, kind_data);
        set_register(REG_WIDTH, dim_value());
        set_register(REG_HEIGHT, dim_value());
        if ($urandom_range(0, 2) == 0)
            set_register(REG_SPARE, CFG_DATA_W'($urandom_range(0, DATA_MAX)));
        repeat (count) random_pixel();
    endtask

    initial begin
        int i;
        sb = new();
        i_rst_n    = 1'b0;
        pix.valid  = 1'b0;
        pix.column = '0;
        pix.row    = '0;
        cfg.valid  = 1'b0;
        cfg.index  = REG_KIND;
        cfg.data   = '0;
        send_calm  = 1'b0;
        take_calm  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The reset setting is a gradient over a 640x480 frame: the
        // first row, the last row, and a row far past the height that must saturate.
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd1, 11'd479);
        send_pixel(11'd2047, 11'd2047);

        // Checkerboard: both sides of a cell corner and the far right edge.
        set_register(REG_KIND, CFG_DATA_W'(KIND_CHECKER));
        send_pixel(11'd31, 11'd31);
        send_pixel(11'd32, 11'd0);
        send_pixel(11'd32, 11'd32);
        send_pixel(11'd2047, 11'd1);

        // Colour bars on a 640 wide frame: bar borders, the last bar, and the first
        // position past the eighth bar, which must be blank with neutral chroma.
        set_register(REG_KIND, CFG_DATA_W'(KIND_BARS));
        set_register(REG_WIDTH, 12'd640);
        send_pixel(11'd79, 11'd0);
        send_pixel(11'd80, 11'd2);
        send_pixel(11'd560, 11'd0);
        send_pixel(11'd639, 11'd1);
        send_pixel(11'd640, 11'd0);

        // A zero width counts as the narrowest frame, with bars one pixel wide.
        set_register(REG_WIDTH, 12'd0);
        send_pixel(11'd7, 11'd0);
        send_pixel(11'd8, 11'd0);

        // An oversized width is clamped, so the last column sits in the last bar.
        set_register(REG_WIDTH, 12'd4095);
        send_pixel(11'd2047, 11'd2046);

        // Crosshatch: a line column, a line row, and a point off both lines.
        set_register(REG_KIND, CFG_DATA_W'(KIND_CROSS));
        send_pixel(11'd0, 11'd5);
        send_pixel(11'd5, 11'd0);
        send_pixel(11'd33, 11'd33);

        // Blank code with every upper data bit set as well.
        set_register(REG_KIND, {{(CFG_DATA_W - KIND_W){1'b1}}, KIND_BLANK_LAST});
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd2046, 11'd2046);

        // Gradient with a zero height, which counts as one row: row 1 is already full scale.
        set_register(REG_KIND, CFG_DATA_W'(KIND_GRADIENT));
        set_register(REG_HEIGHT, 12'd0);
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd1, 11'd1);

        // An oversized height is clamped, so the last row stays just below full scale.
        set_register(REG_HEIGHT, 12'd4095);
        send_pixel(11'd2047, 11'd2047);

        // A write to the undecoded index must leave the gradient setting alone.
        set_register(REG_SPARE, 12'd1);
        send_pixel(11'd2047, 11'd0);

        // Random part.
        for (i = 0; i < PHASES; i++) begin
            random_phase(ITEMS_PER_PHASE);
        end

        drain_pixels();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending_samples.size() != 0)
            sb.note_failure($sformatf("%0d results never arrived",
                                      sb.pending_samples.size()));

        if (sb.failures == 0) begin
            $display("tb_yuv420_test_pattern_generator passed");
        end else begin
            $display("tb_yuv420_test_pattern_generator failed");
        end
        $finish;
    end

endmodule
